[rtl/gcra_pkg.sv]
// gcra_pkg: shared types, codes and widths for the gcra rate limiter table
// used by gcra_ctrl, gcra_dp and gcra_rate_limiter_table_top; no dependencies
`default_nettype none

package gcra_pkg;

  localparam int LABELS_DEF = 16;
  localparam int SCALE_DEF  = 1000000;

  localparam int CMD_W     = 2;
  localparam int LABEL_W   = 4;
  localparam int TIME_W    = 63;
  localparam int COUNT_W   = 63;
  localparam int PLEN_W    = 64;
  localparam int STATUS_W  = 3;
  localparam int DIV_STEPS = TIME_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CMD_W-1:0] CMD_DEFINE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DEFINED  = 3'd0,
    STAT_ALLOWED  = 3'd1,
    STAT_EXCEEDED = 3'd2,
    STAT_NOTHING  = 3'd3,
    STAT_NO_SPEC  = 3'd4,
    STAT_BAD_SPEC = 3'd5,
    STAT_CLEARED  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_ZERO,
    WR_DEFINE,
    WR_ADMIT
  } wr_op_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_MUL_HI,
    S_DIV_INIT,
    S_DIV,
    S_SUM,
    S_NEED,
    S_JUDGE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    sweep;
    logic    load;
    logic    raise;
    logic    mul_lo;
    logic    mul_hi;
    logic    div_init;
    logic    div_step;
    logic    chk_sum;
    logic    chk_need;
    logic    finish;
    wr_op_t  wr_op;
    status_t status;
  } dp_ctrl_t;

  typedef struct packed {
    logic sweep_last;
    logic is_clear;
    logic is_define;
    logic bad_spec;
    logic no_spec;
    logic small_limit;
    logic div_last;
    logic cost_zero;
    logic fits;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/gcra_rate_limiter_table_top.sv]
// gcra_rate_limiter_table_top: a request runs the 63-step serial divider; define,
// clear and bad or missing spec items skip it. the next item is taken in S_IDLE after
// S_DONE; a result waiting in the output register does not block taking it, only its
// S_DONE. after reset a clearing pass zeroes the tables, items stalled meanwhile.
// rst_n is synchronous and active low; uses gcra_pkg, gcra_ctrl and gcra_dp
`default_nettype none

module gcra_rate_limiter_table_top #(
  parameter int LABELS = gcra_pkg::LABELS_DEF,
  parameter int SCALE  = gcra_pkg::SCALE_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [gcra_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [gcra_pkg::LABEL_W-1:0]       in_label_index,
  input  wire logic [gcra_pkg::TIME_W-1:0]        in_now,
  input  wire logic                               in_spec_given,
  input  wire logic [gcra_pkg::COUNT_W-1:0]       in_allowed_count,
  input  wire logic signed [gcra_pkg::PLEN_W-1:0] in_period_len,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [gcra_pkg::STATUS_W-1:0]           out_status,
  output logic [gcra_pkg::TIME_W-1:0]             out_next_tip
);

  gcra_pkg::dp_ctrl_t ctrl;
  gcra_pkg::dp_stat_t stat;

  gcra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  gcra_dp #(
    .LABELS (LABELS),
    .SCALE  (SCALE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_cmd           (in_cmd),
    .in_label_index   (in_label_index),
    .in_now           (in_now),
    .in_spec_given    (in_spec_given),
    .in_allowed_count (in_allowed_count),
    .in_period_len    (in_period_len),
    .out_status       (out_status),
    .out_next_tip     (out_next_tip)
  );

endmodule

`default_nettype wire

[rtl/gcra_dp.sv]
// gcra_dp: item registers, entry memories, cost multiplier, serial divider,
// admission checks and result register; uses gcra_pkg, driven by gcra_ctrl
`default_nettype none

module gcra_dp #(
  parameter int LABELS = gcra_pkg::LABELS_DEF,
  parameter int SCALE  = gcra_pkg::SCALE_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire gcra_pkg::dp_ctrl_t                    ctrl,
  output gcra_pkg::dp_stat_t                         stat,
  input  wire logic [gcra_pkg::CMD_W-1:0]            in_cmd,
  input  wire logic [gcra_pkg::LABEL_W-1:0]          in_label_index,
  input  wire logic [gcra_pkg::TIME_W-1:0]           in_now,
  input  wire logic                                  in_spec_given,
  input  wire logic [gcra_pkg::COUNT_W-1:0]          in_allowed_count,
  input  wire logic signed [gcra_pkg::PLEN_W-1:0]    in_period_len,
  output logic [gcra_pkg::STATUS_W-1:0]              out_status,
  output logic [gcra_pkg::TIME_W-1:0]                out_next_tip
);

  localparam int TW         = gcra_pkg::TIME_W;
  localparam int CW         = gcra_pkg::COUNT_W;
  localparam int IDX_W      = (LABELS > 1) ? $clog2(LABELS) : 1;
  localparam int LABEL_SPAN = 2 ** gcra_pkg::LABEL_W;
  localparam int SCALE_W    = $clog2(SCALE + 1);
  localparam int LO_W       = 32;
  localparam int HI_W       = TW - LO_W;
  localparam int NUM_W      = TW + SCALE_W;
  localparam logic [SCALE_W-1:0] SCALE_V = SCALE_W'(SCALE);
  localparam logic [CW-1:0]      SCALE_C = CW'(SCALE);

  logic [TW-1:0] tip_mem [LABELS];
  logic [CW-1:0] cnt_mem [LABELS];
  logic [TW-1:0] per_mem [LABELS];

  logic [IDX_W-1:0] wrap_lut [LABEL_SPAN];

  for (genvar g = 0; g < LABEL_SPAN; g++) begin : g_wrap
    localparam int WRAPPED = g % LABELS;
    assign wrap_lut[g] = IDX_W'(WRAPPED);
  end

  logic [gcra_pkg::CMD_W-1:0] cmd_r;
  logic [IDX_W-1:0]           idx_r;
  logic [TW-1:0]              now_r;
  logic                       given_r;
  logic [CW-1:0]              cnt_in_r;
  logic [gcra_pkg::PLEN_W-1:0] plen_r;

  logic [TW-1:0] tip_rd_r;
  logic [CW-1:0] lim_rd_r;
  logic [TW-1:0] per_rd_r;

  logic [TW-1:0] tip_r;
  logic [CW-1:0] lim_r;
  logic [TW-1:0] per_r;

  logic [LO_W+SCALE_W-1:0] pp_lo_r;
  logic [HI_W+SCALE_W-1:0] pp_hi_r;
  logic [NUM_W-1:0]        num;

  logic [CW-1:0]                     rem_r;
  logic [TW-1:0]                     quo_r;
  logic [gcra_pkg::DIV_CNT_W-1:0]    div_cnt_r;
  logic [CW:0]                       trial;
  logic [CW+1:0]                     diff;
  logic                              ge;

  logic [TW-1:0] slack_r;
  logic [TW:0]   nt_r;
  logic [TW:0]   need_r;
  logic [TW-1:0] nt_sat;

  logic [IDX_W-1:0] sweep_cnt_r;
  logic [IDX_W-1:0] waddr;
  logic             we;
  logic [TW-1:0]    wr_tip;
  logic [CW-1:0]    wr_cnt;
  logic [TW-1:0]    wr_per;

  logic [gcra_pkg::STATUS_W-1:0] out_status_r;
  logic [TW-1:0]                 out_next_tip_r;

  // item capture and registered memory read
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r    <= in_cmd;
      idx_r    <= wrap_lut[in_label_index];
      now_r    <= in_now;
      given_r  <= in_spec_given;
      cnt_in_r <= in_allowed_count;
      plen_r   <= in_period_len;
      tip_rd_r <= tip_mem[wrap_lut[in_label_index]];
      lim_rd_r <= cnt_mem[wrap_lut[in_label_index]];
      per_rd_r <= per_mem[wrap_lut[in_label_index]];
    end
  end

  // raised tip and effective spec
  always_ff @(posedge clk) begin
    if (ctrl.raise) begin
      tip_r <= (tip_rd_r < now_r) ? now_r : tip_rd_r;
      lim_r <= given_r ? cnt_in_r : lim_rd_r;
      per_r <= given_r ? plen_r[TW-1:0] : per_rd_r;
    end
  end

  // cost numerator period * scale in two partial products
  always_ff @(posedge clk) begin
    if (ctrl.mul_lo) begin
      pp_lo_r <= per_r[LO_W-1:0] * SCALE_V;
    end
    if (ctrl.mul_hi) begin
      pp_hi_r <= per_r[TW-1:LO_W] * SCALE_V;
    end
  end

  assign num = NUM_W'(pp_lo_r) + (NUM_W'(pp_hi_r) << LO_W);

  // restoring divider, one quotient bit per cycle
  assign trial = {rem_r, quo_r[TW-1]};
  assign diff  = {1'b0, trial} - {2'b00, lim_r};
  assign ge    = ~diff[CW+1];

  always_ff @(posedge clk) begin
    if (ctrl.div_init) begin
      rem_r <= CW'(num >> TW);
      quo_r <= num[TW-1:0];
    end else if (ctrl.div_step) begin
      rem_r <= ge ? diff[CW-1:0] : trial[CW-1:0];
      quo_r <= {quo_r[TW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (ctrl.div_init) begin
      div_cnt_r <= '0;
    end else if (ctrl.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // admission checks
  always_ff @(posedge clk) begin
    if (ctrl.chk_sum) begin
      slack_r <= tip_r - now_r;
      nt_r    <= {1'b0, tip_r} + {1'b0, quo_r};
    end
    if (ctrl.chk_need) begin
      need_r <= {1'b0, slack_r} + {1'b0, quo_r};
    end
  end

  assign nt_sat = nt_r[TW] ? {TW{1'b1}} : nt_r[TW-1:0];

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
    end else if (ctrl.sweep) begin
      sweep_cnt_r <= sweep_cnt_r + 1'b1;
    end
  end

  always_comb begin
    we     = 1'b0;
    waddr  = idx_r;
    wr_tip = '0;
    wr_cnt = '0;
    wr_per = '0;
    if (ctrl.sweep) begin
      we    = 1'b1;
      waddr = sweep_cnt_r;
    end else if (ctrl.finish) begin
      case (ctrl.wr_op)
        gcra_pkg::WR_ZERO: begin
          we = 1'b1;
        end
        gcra_pkg::WR_DEFINE: begin
          we     = 1'b1;
          wr_tip = tip_r;
          wr_cnt = lim_r;
          wr_per = per_r;
        end
        gcra_pkg::WR_ADMIT: begin
          we     = 1'b1;
          wr_tip = nt_sat;
          wr_cnt = lim_r;
          wr_per = per_r;
        end
        default: begin
          wr_tip = tip_rd_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tip_mem[waddr] <= wr_tip;
      cnt_mem[waddr] <= wr_cnt;
      per_mem[waddr] <= wr_per;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_status_r   <= ctrl.status;
      out_next_tip_r <= wr_tip;
    end
  end

  assign out_status   = out_status_r;
  assign out_next_tip = out_next_tip_r;

  assign stat.sweep_last  = (sweep_cnt_r == IDX_W'(LABELS - 1));
  assign stat.is_clear    = (cmd_r >= gcra_pkg::CMD_CLEAR);
  assign stat.is_define   = (cmd_r == gcra_pkg::CMD_DEFINE);
  assign stat.bad_spec    = given_r && (plen_r[gcra_pkg::PLEN_W-1] || (plen_r == '0));
  assign stat.no_spec     = !given_r && (per_rd_r == '0);
  assign stat.small_limit = (lim_r < SCALE_C);
  assign stat.div_last    = (div_cnt_r == gcra_pkg::DIV_CNT_W'(gcra_pkg::DIV_STEPS - 1));
  assign stat.cost_zero   = (quo_r == '0);
  assign stat.fits        = (need_r <= {1'b0, per_r});

endmodule

`default_nettype wire

[rtl/gcra_ctrl.sv]
// gcra_ctrl: command sequencer for the gcra rate limiter table
// uses gcra_pkg; steers gcra_dp and owns the channel handshakes
`default_nettype none

module gcra_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output gcra_pkg::dp_ctrl_t      ctrl,
  input  wire gcra_pkg::dp_stat_t stat
);

  gcra_pkg::state_t  state_r,  state_nxt;
  gcra_pkg::wr_op_t  wr_op_r,  wr_op_nxt;
  gcra_pkg::status_t status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcra_pkg::S_SWEEP;
      wr_op_r     <= gcra_pkg::WR_NONE;
      status_r    <= gcra_pkg::STAT_DEFINED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_op_r     <= wr_op_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    wr_op_nxt  = wr_op_r;
    status_nxt = status_r;
    ctrl       = '0;
    case (state_r)
      gcra_pkg::S_SWEEP: begin
        ctrl.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = gcra_pkg::S_IDLE;
        end
      end
      gcra_pkg::S_IDLE: begin
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_nxt = gcra_pkg::S_LOOK;
        end
      end
      gcra_pkg::S_LOOK: begin
        ctrl.raise = 1'b1;
        if (stat.is_clear) begin
          wr_op_nxt  = gcra_pkg::WR_ZERO;
          status_nxt = gcra_pkg::STAT_CLEARED;
          state_nxt  = gcra_pkg::S_DONE;
        end else begin
          state_nxt = gcra_pkg::S_DECIDE;
        end
      end
      gcra_pkg::S_DECIDE: begin
        state_nxt = gcra_pkg::S_DONE;
        wr_op_nxt = gcra_pkg::WR_NONE;
        if (stat.bad_spec) begin
          status_nxt = gcra_pkg::STAT_BAD_SPEC;
        end else if (stat.no_spec) begin
          status_nxt = gcra_pkg::STAT_NO_SPEC;
        end else if (stat.is_define) begin
          wr_op_nxt  = gcra_pkg::WR_DEFINE;
          status_nxt = gcra_pkg::STAT_DEFINED;
        end else if (stat.small_limit) begin
          status_nxt = gcra_pkg::STAT_NOTHING;
        end else begin
          ctrl.mul_lo = 1'b1;
          state_nxt   = gcra_pkg::S_MUL_HI;
        end
      end
      gcra_pkg::S_MUL_HI: begin
        ctrl.mul_hi = 1'b1;
        state_nxt   = gcra_pkg::S_DIV_INIT;
      end
      gcra_pkg::S_DIV_INIT: begin
        ctrl.div_init = 1'b1;
        state_nxt     = gcra_pkg::S_DIV;
      end
      gcra_pkg::S_DIV: begin
        ctrl.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = gcra_pkg::S_SUM;
        end
      end
      gcra_pkg::S_SUM: begin
        ctrl.chk_sum = 1'b1;
        state_nxt    = gcra_pkg::S_NEED;
      end
      gcra_pkg::S_NEED: begin
        ctrl.chk_need = 1'b1;
        state_nxt     = gcra_pkg::S_JUDGE;
      end
      gcra_pkg::S_JUDGE: begin
        state_nxt = gcra_pkg::S_DONE;
        if (!stat.cost_zero && stat.fits) begin
          wr_op_nxt  = gcra_pkg::WR_ADMIT;
          status_nxt = gcra_pkg::STAT_ALLOWED;
        end else begin
          wr_op_nxt  = gcra_pkg::WR_NONE;
          status_nxt = stat.cost_zero ? gcra_pkg::STAT_NOTHING : gcra_pkg::STAT_EXCEEDED;
        end
      end
      gcra_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          ctrl.finish = 1'b1;
          ctrl.wr_op  = wr_op_r;
          ctrl.status = status_r;
          state_nxt   = gcra_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gcra_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = ctrl.finish || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;
  assign in_stall      = (state_r != gcra_pkg::S_IDLE);

endmodule

`default_nettype wire
